// File: rtl/apss_pkg.sv
// types, constants and task-file codes shared by the ata pio sector sequencer
package apss_pkg;

    localparam int WORDS_PER_SECTOR = 256;
    localparam int WCW = $clog2(WORDS_PER_SECTOR + 1);

    localparam int IN_W  = 48;
    localparam int OUT_W = 56;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 29;

    // request and reply codes on the input stream
    localparam logic [2:0] ACT_PROBE    = 3'd0;
    localparam logic [2:0] ACT_READ     = 3'd1;
    localparam logic [2:0] ACT_WRITE    = 3'd2;
    localparam logic [2:0] ACT_REPLY    = 3'd3;
    localparam logic [2:0] ACT_HOST_WR  = 3'd4;

    // bus access kinds
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_RB   = 3'd1;
    localparam logic [2:0] OP_WB   = 3'd2;
    localparam logic [2:0] OP_RW   = 3'd3;
    localparam logic [2:0] OP_WW   = 3'd4;

    // result codes
    localparam logic [1:0] RC_OK      = 2'd0;
    localparam logic [1:0] RC_NO_DISK = 2'd1;
    localparam logic [1:0] RC_RANGE   = 2'd2;
    localparam logic [1:0] RC_BUSY    = 2'd3;

    // task-file register offsets
    localparam logic [15:0] REG_DATA     = 16'd0;
    localparam logic [15:0] REG_SECCOUNT = 16'd2;
    localparam logic [15:0] REG_LBA_LO   = 16'd3;
    localparam logic [15:0] REG_LBA_MID  = 16'd4;
    localparam logic [15:0] REG_LBA_HI   = 16'd5;
    localparam logic [15:0] REG_DRIVE    = 16'd6;
    localparam logic [15:0] REG_CMD      = 16'd7;

    localparam logic [7:0] DRIVE_SEL    = 8'hA0;
    localparam logic [7:0] DRIVE_LBA    = 8'hE0;
    localparam logic [7:0] CMD_IDENTIFY = 8'hEC;
    localparam logic [7:0] CMD_READ     = 8'h20;
    localparam logic [7:0] CMD_WRITE    = 8'h30;
    localparam logic [7:0] CMD_FLUSH    = 8'hE7;

    localparam int ST_BSY = 7;
    localparam int ST_DRQ = 3;
    localparam int ST_ERR = 0;

    localparam logic [15:0] IO_BASE_RST     = 16'h01F0;
    localparam logic [28:0] MAX_SECTORS_RST = 29'h1000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_IO_BASE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SECTORS = 1'd1;

    typedef enum logic [3:0] {
        PH_IDLE, PH_PR_FIRST, PH_PR_BUSY, PH_PR_CHECK, PH_PR_DATA,
        PH_RD_BUSY, PH_RD_DRQ, PH_RD_DATA,
        PH_WR_BUSY, PH_WR_DRQ, PH_WR_DATA, PH_WR_FLUSH
    } phase_t;

    // what burst of results an accepted item leaves behind
    typedef enum logic [3:0] {
        K_NONE, K_FINISH, K_PROBE, K_ISSUE_RD, K_ISSUE_WR, K_STATUS,
        K_RWORD, K_RDATA, K_RLAST, K_WWORD, K_WFLUSH
    } kind_t;

    function automatic logic [2:0] kind_count(input kind_t k);
        logic [2:0] n;
        begin
            case (k)
                K_NONE:                          n = 3'd0;
                K_PROBE, K_ISSUE_RD, K_ISSUE_WR: n = 3'd7;
                K_WFLUSH:                        n = 3'd3;
                default:                         n = 3'd1;
            endcase
            return n;
        end
    endfunction

endpackage

// File: rtl/ata_pio_sector_sequencer_unit.sv
// Host-side ATA PIO sequencer for single LBA28 sectors. Each input item is a
// request (probe, read, write), a bus read reply or a host write word; it is
// decoded and the phase, word count and presence flag updated in the cycle it
// is accepted, and the results it causes leave one per cycle, while the output
// is ready, from a registered descriptor. An item causing one result or none is
// taken every cycle while the output is ready; an item causing n results (up to
// seven for a command issue) holds the input until its last result leaves, the
// next item being taken in that cycle. The output stream sets the rate.
module ata_pio_sector_sequencer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // action[2:0], sector[30:3], word_in[46:31], zero[47]
    input  logic [apss_pkg::IN_W-1:0]       s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // bus_op[2:0], bus_address[18:3], bus_data[34:19], host_word[50:35],
    // done_res[51], result_code[53:52], disk_found[54], zero[55]
    output logic [apss_pkg::OUT_W-1:0]      m_tdata,
    // host_word_valid[0]
    output logic                            m_tuser,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [apss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import apss_pkg::*;

    logic [15:0]    io_base_reg;
    logic [28:0]    max_sectors_reg;
    phase_t         phase_reg, phase_next;
    logic [WCW-1:0] wc_reg, wc_next, wc_inc;
    logic           present_reg, present_next;

    kind_t          kind_reg, kind_next;
    logic [2:0]     idx_reg;
    logic [2:0]     cnt_w;
    logic           busy_reg;
    logic [27:0]    sector_reg;
    logic [15:0]    word_reg;
    logic [1:0]     code_reg, code_next;

    logic [2:0]     in_action;
    logic [27:0]    in_sector;
    logic [15:0]    in_word;
    logic [7:0]     st;
    logic           accept, take, last_w;

    logic [2:0]     op;
    logic [15:0]    off, bdata, hword;
    logic           hvalid, done;
    logic [1:0]     rcode;
    logic [15:0]    addr;

    assign in_action = s_tdata[2:0];
    assign in_sector = s_tdata[30:3];
    assign in_word   = s_tdata[46:31];
    assign st        = in_word[7:0];
    assign wc_inc    = wc_reg + WCW'(1);

    assign cnt_w    = kind_count(kind_reg);
    assign last_w   = (idx_reg == cnt_w - 3'd1);
    assign take     = busy_reg && m_tready;
    assign s_tready = !busy_reg || (m_tready && last_w);
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            io_base_reg     <= IO_BASE_RST;
            max_sectors_reg <= MAX_SECTORS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IO_BASE:     io_base_reg <= cfg_data[15:0];
                CFG_MAX_SECTORS: max_sectors_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // decode of one item against the current phase
    always_comb
    begin
        phase_next   = phase_reg;
        wc_next      = wc_reg;
        present_next = present_reg;
        kind_next    = K_NONE;
        code_next    = RC_OK;
        if (in_action == ACT_PROBE || in_action == ACT_READ || in_action == ACT_WRITE)
        begin
            if (phase_reg != PH_IDLE)
            begin
                kind_next = K_FINISH;
                code_next = RC_BUSY;
            end
            else if (in_action == ACT_PROBE)
            begin
                kind_next  = K_PROBE;
                phase_next = PH_PR_FIRST;
            end
            else if (!present_reg)
            begin
                kind_next = K_FINISH;
                code_next = RC_NO_DISK;
            end
            else if ({1'b0, in_sector} >= max_sectors_reg)
            begin
                kind_next = K_FINISH;
                code_next = RC_RANGE;
            end
            else if (in_action == ACT_READ)
            begin
                kind_next  = K_ISSUE_RD;
                phase_next = PH_RD_BUSY;
            end
            else
            begin
                kind_next  = K_ISSUE_WR;
                phase_next = PH_WR_BUSY;
            end
        end
        else if (in_action == ACT_REPLY)
        begin
            case (phase_reg)
                PH_PR_FIRST:
                begin
                    if (st == 8'd0)
                    begin
                        present_next = 1'b0;
                        phase_next   = PH_IDLE;
                        kind_next    = K_FINISH;
                        code_next    = RC_NO_DISK;
                    end
                    else
                    begin
                        kind_next  = K_STATUS;
                        phase_next = PH_PR_BUSY;
                    end
                end
                PH_PR_BUSY:
                begin
                    kind_next = K_STATUS;
                    if (!st[ST_BSY])
                        phase_next = PH_PR_CHECK;
                end
                PH_PR_CHECK:
                begin
                    if (st[ST_ERR] || !st[ST_DRQ])
                    begin
                        present_next = 1'b0;
                        phase_next   = PH_IDLE;
                        kind_next    = K_FINISH;
                        code_next    = RC_NO_DISK;
                    end
                    else
                    begin
                        wc_next    = '0;
                        kind_next  = K_RWORD;
                        phase_next = PH_PR_DATA;
                    end
                end
                PH_PR_DATA:
                begin
                    if (wc_inc < WCW'(WORDS_PER_SECTOR))
                    begin
                        wc_next   = wc_inc;
                        kind_next = K_RWORD;
                    end
                    else
                    begin
                        wc_next      = '0;
                        present_next = 1'b1;
                        phase_next   = PH_IDLE;
                        kind_next    = K_FINISH;
                        code_next    = RC_OK;
                    end
                end
                PH_RD_BUSY:
                begin
                    kind_next = K_STATUS;
                    if (!st[ST_BSY])
                        phase_next = PH_RD_DRQ;
                end
                PH_WR_BUSY:
                begin
                    kind_next = K_STATUS;
                    if (!st[ST_BSY])
                        phase_next = PH_WR_DRQ;
                end
                PH_RD_DRQ:
                begin
                    if (st[ST_ERR] || st[ST_DRQ])
                    begin
                        wc_next    = '0;
                        kind_next  = K_RWORD;
                        phase_next = PH_RD_DATA;
                    end
                    else
                        kind_next = K_STATUS;
                end
                PH_WR_DRQ:
                begin
                    // data phase entry gives no result
                    if (st[ST_ERR] || st[ST_DRQ])
                    begin
                        wc_next    = '0;
                        phase_next = PH_WR_DATA;
                    end
                    else
                        kind_next = K_STATUS;
                end
                PH_RD_DATA:
                begin
                    if (wc_inc < WCW'(WORDS_PER_SECTOR))
                    begin
                        wc_next   = wc_inc;
                        kind_next = K_RDATA;
                    end
                    else
                    begin
                        wc_next    = '0;
                        phase_next = PH_IDLE;
                        kind_next  = K_RLAST;
                    end
                end
                PH_WR_FLUSH:
                begin
                    if (st[ST_BSY])
                        kind_next = K_STATUS;
                    else
                    begin
                        phase_next = PH_IDLE;
                        kind_next  = K_FINISH;
                        code_next  = RC_OK;
                    end
                end
                default: ;
            endcase
        end
        else if (in_action == ACT_HOST_WR && phase_reg == PH_WR_DATA)
        begin
            if (wc_inc >= WCW'(WORDS_PER_SECTOR))
            begin
                wc_next    = '0;
                phase_next = PH_WR_FLUSH;
                kind_next  = K_WFLUSH;
            end
            else
            begin
                wc_next   = wc_inc;
                kind_next = K_WWORD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            wc_reg      <= '0;
            present_reg <= 1'b0;
            busy_reg    <= 1'b0;
            kind_reg    <= K_NONE;
            idx_reg     <= '0;
            code_reg    <= RC_OK;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            wc_reg      <= wc_next;
            present_reg <= present_next;
            busy_reg    <= (kind_next != K_NONE);
            kind_reg    <= kind_next;
            idx_reg     <= '0;
            code_reg    <= code_next;
        end
        else if (take)
        begin
            if (last_w)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sector_reg <= in_sector;
            word_reg   <= in_word;
        end
    end

    // one result of the current burst
    always_comb
    begin
        op     = OP_NONE;
        off    = REG_DATA;
        bdata  = '0;
        hword  = '0;
        hvalid = 1'b0;
        done   = 1'b0;
        rcode  = RC_OK;
        case (kind_reg)
            K_FINISH:
            begin
                done  = 1'b1;
                rcode = code_reg;
            end
            K_PROBE, K_ISSUE_RD, K_ISSUE_WR:
            begin
                op = OP_WB;
                case (idx_reg)
                    3'd0:
                    begin
                        off   = REG_DRIVE;
                        bdata = (kind_reg == K_PROBE) ? {8'd0, DRIVE_SEL}
                                : {8'd0, DRIVE_LBA | {4'd0, sector_reg[27:24]}};
                    end
                    3'd1:
                    begin
                        off   = REG_SECCOUNT;
                        bdata = (kind_reg == K_PROBE) ? 16'd0 : 16'd1;
                    end
                    3'd2:
                    begin
                        off   = REG_LBA_LO;
                        bdata = (kind_reg == K_PROBE) ? 16'd0 : {8'd0, sector_reg[7:0]};
                    end
                    3'd3:
                    begin
                        off   = REG_LBA_MID;
                        bdata = (kind_reg == K_PROBE) ? 16'd0 : {8'd0, sector_reg[15:8]};
                    end
                    3'd4:
                    begin
                        off   = REG_LBA_HI;
                        bdata = (kind_reg == K_PROBE) ? 16'd0 : {8'd0, sector_reg[23:16]};
                    end
                    3'd5:
                    begin
                        off = REG_CMD;
                        case (kind_reg)
                            K_PROBE:    bdata = {8'd0, CMD_IDENTIFY};
                            K_ISSUE_RD: bdata = {8'd0, CMD_READ};
                            default:    bdata = {8'd0, CMD_WRITE};
                        endcase
                    end
                    default:
                    begin
                        op  = OP_RB;
                        off = REG_CMD;
                    end
                endcase
            end
            K_STATUS:
            begin
                op  = OP_RB;
                off = REG_CMD;
            end
            K_RWORD:
                op = OP_RW;
            K_RDATA:
            begin
                op     = OP_RW;
                hword  = word_reg;
                hvalid = 1'b1;
            end
            K_RLAST:
            begin
                hword  = word_reg;
                hvalid = 1'b1;
                done   = 1'b1;
            end
            K_WWORD:
            begin
                op    = OP_WW;
                bdata = word_reg;
            end
            K_WFLUSH:
            begin
                case (idx_reg)
                    3'd0:
                    begin
                        op    = OP_WW;
                        bdata = word_reg;
                    end
                    3'd1:
                    begin
                        op    = OP_WB;
                        off   = REG_CMD;
                        bdata = {8'd0, CMD_FLUSH};
                    end
                    default:
                    begin
                        op  = OP_RB;
                        off = REG_CMD;
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign addr = (op == OP_NONE) ? 16'd0 : io_base_reg + off;

    assign m_tdata  = {1'b0, present_reg, rcode, done, hword, bdata, addr, op};
    assign m_tuser  = hvalid;
    assign m_tlast  = last_w;
    assign m_tvalid = busy_reg;

    a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg < cnt_w))
        else $error("result index beyond burst length");

    a_take_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && busy_reg) |-> (m_tready && last_w))
        else $error("item accepted with results still pending");

    a_wc_range: assert property (@(posedge clk) disable iff (!rst_n)
        wc_reg < WCW'(WORDS_PER_SECTOR))
        else $error("word count out of range");

    a_idle_wc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (wc_reg == '0))
        else $error("word count left nonzero at idle");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && done) |-> last_w)
        else $error("done result not last of its burst");

    a_present_from_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (present_reg && !$past(present_reg)) |-> ($past(phase_reg) == PH_PR_DATA))
        else $error("presence flag set outside identify data phase");

endmodule

// File: bench/testbench.sv
// self-checking bench for the ata pio sector sequencer: predicted task-file accesses vs output stream
`timescale 1ns / 1ps

module testbench;

    import apss_pkg::*;

    // action codes the block has no use for
    localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [2:0] ACT_SPARE_MID = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI  = 3'd7;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int REQS_PER_PASS = 6;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [15:0] data;
        logic [15:0] hword;
        logic        hvalid;
        logic        done;
        logic [1:0]  code;
        logic        found;
        logic        is_last;
    } bus_result_t;

    typedef enum {EXP_MODEL, EXP_NONE, EXP_ONE} expect_mode_t;

    typedef struct {
        logic [2:0]   act;
        logic [27:0]  sec;
        logic [15:0]  wrd;
        expect_mode_t mode;
        logic [1:0]   code;
        logic         found;
        logic         complete;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic [IN_W-1:0]       s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state and configuration
    phase_t      seq_phase;
    int          words_done;
    logic        model_present;
    logic [15:0] io_base_r;
    logic [28:0] sector_limit;

    bus_result_t step_out[$];
    bus_result_t predicted_accesses[$];
    bus_result_t seen;
    stim_row_t   plan[$];
    int          mismatches;
    int          burst_left;
    int          hold_request;

    ata_pio_sector_sequencer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    initial
    begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic string show(input bus_result_t r);
        return $sformatf("op=%0d addr=%h data=%h hw=%h hv=%0d done=%0d rc=%0d disk=%0d last=%0d",
                         r.op, r.addr, r.data, r.hword, r.hvalid, r.done, r.code, r.found,
                         r.is_last);
    endfunction

    task automatic add_access(input logic [2:0] op, input logic [15:0] off,
                              input logic [15:0] data, input logic [15:0] hw,
                              input logic hv, input logic done, input logic [1:0] code);
        bus_result_t r;
        r.op      = op;
        r.addr    = (op == OP_NONE) ? 16'd0 : io_base_r + off;
        r.data    = data;
        r.hword   = hw;
        r.hvalid  = hv;
        r.done    = done;
        r.code    = done ? code : RC_OK;
        r.found   = 1'b0;
        r.is_last = 1'b0;
        step_out.push_back(r);
    endtask

    task automatic complete(input logic [1:0] code);
        add_access(OP_NONE, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, code);
    endtask

    task automatic poll_status();
        add_access(OP_RB, REG_CMD, 16'd0, 16'd0, 1'b0, 1'b0, RC_OK);
    endtask

    task automatic task_write(input logic [15:0] off, input logic [7:0] data);
        add_access(OP_WB, off, {8'h00, data}, 16'd0, 1'b0, 1'b0, RC_OK);
    endtask

    task automatic word_read(input logic [15:0] hw, input logic hv);
        add_access(OP_RW, REG_DATA, 16'd0, hw, hv, 1'b0, RC_OK);
    endtask

    // works out the results of one accepted item into step_out
    task automatic sequencer_step(input logic [2:0] act, input logic [27:0] sec,
                                  input logic [15:0] wrd);
        logic [7:0] st;
        st = wrd[7:0];
        step_out = {};
        if (act <= ACT_WRITE)
        begin
            if (seq_phase != PH_IDLE)
                complete(RC_BUSY);
            else if (act == ACT_PROBE)
            begin
                task_write(REG_DRIVE, DRIVE_SEL);
                task_write(REG_SECCOUNT, 8'h00);
                task_write(REG_LBA_LO, 8'h00);
                task_write(REG_LBA_MID, 8'h00);
                task_write(REG_LBA_HI, 8'h00);
                task_write(REG_CMD, CMD_IDENTIFY);
                poll_status();
                seq_phase = PH_PR_FIRST;
            end
            else if (!model_present)
                complete(RC_NO_DISK);
            else if ({1'b0, sec} >= sector_limit)
                complete(RC_RANGE);
            else
            begin
                task_write(REG_DRIVE, DRIVE_LBA | {4'h0, sec[27:24]});
                task_write(REG_SECCOUNT, 8'h01);
                task_write(REG_LBA_LO, sec[7:0]);
                task_write(REG_LBA_MID, sec[15:8]);
                task_write(REG_LBA_HI, sec[23:16]);
                task_write(REG_CMD, (act == ACT_READ) ? CMD_READ : CMD_WRITE);
                poll_status();
                seq_phase = (act == ACT_READ) ? PH_RD_BUSY : PH_WR_BUSY;
            end
        end
        else if (act == ACT_REPLY)
        begin
            case (seq_phase)
                PH_PR_FIRST:
                    if (st == 8'h00)
                    begin
                        model_present = 1'b0;
                        seq_phase = PH_IDLE;
                        complete(RC_NO_DISK);
                    end
                    else
                    begin
                        poll_status();
                        seq_phase = PH_PR_BUSY;
                    end
                PH_PR_BUSY:
                begin
                    poll_status();
                    if (!st[ST_BSY])
                        seq_phase = PH_PR_CHECK;
                end
                PH_PR_CHECK:
                    if (st[ST_ERR] || !st[ST_DRQ])
                    begin
                        model_present = 1'b0;
                        seq_phase = PH_IDLE;
                        complete(RC_NO_DISK);
                    end
                    else
                    begin
                        words_done = 0;
                        word_read(16'd0, 1'b0);
                        seq_phase = PH_PR_DATA;
                    end
                PH_PR_DATA:
                begin
                    // identify words are consumed, never passed on
                    words_done++;
                    if (words_done < WORDS_PER_SECTOR)
                        word_read(16'd0, 1'b0);
                    else
                    begin
                        model_present = 1'b1;
                        seq_phase = PH_IDLE;
                        words_done = 0;
                        complete(RC_OK);
                    end
                end
                PH_RD_BUSY, PH_WR_BUSY:
                begin
                    poll_status();
                    if (!st[ST_BSY])
                        seq_phase = (seq_phase == PH_RD_BUSY) ? PH_RD_DRQ : PH_WR_DRQ;
                end
                PH_RD_DRQ:
                    if (st[ST_ERR] || st[ST_DRQ])
                    begin
                        words_done = 0;
                        word_read(16'd0, 1'b0);
                        seq_phase = PH_RD_DATA;
                    end
                    else
                        poll_status();
                PH_WR_DRQ:
                    if (st[ST_ERR] || st[ST_DRQ])
                    begin
                        // data phase opens silently
                        words_done = 0;
                        seq_phase = PH_WR_DATA;
                    end
                    else
                        poll_status();
                PH_RD_DATA:
                begin
                    words_done++;
                    if (words_done < WORDS_PER_SECTOR)
                        word_read(wrd, 1'b1);
                    else
                    begin
                        add_access(OP_NONE, 16'd0, 16'd0, wrd, 1'b1, 1'b1, RC_OK);
                        seq_phase = PH_IDLE;
                        words_done = 0;
                    end
                end
                PH_WR_FLUSH:
                    if (st[ST_BSY])
                        poll_status();
                    else
                    begin
                        seq_phase = PH_IDLE;
                        complete(RC_OK);
                    end
                default:
                    ;
            endcase
        end
        else if (act == ACT_HOST_WR && seq_phase == PH_WR_DATA)
        begin
            add_access(OP_WW, REG_DATA, wrd, 16'd0, 1'b0, 1'b0, RC_OK);
            words_done++;
            if (words_done >= WORDS_PER_SECTOR)
            begin
                task_write(REG_CMD, CMD_FLUSH);
                poll_status();
                words_done = 0;
                seq_phase = PH_WR_FLUSH;
            end
        end
        foreach (step_out[k])
        begin
            step_out[k].found   = model_present;
            step_out[k].is_last = (k == step_out.size() - 1);
        end
    endtask

    // offers one item in bursts with random gaps, then queues what it should cause
    task automatic offer(input logic [2:0] act, input logic [27:0] sec, input logic [15:0] wrd,
                         input expect_mode_t mode, input logic [1:0] code, input logic found);
        int gap;
        bus_result_t one;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tdata  <= {1'b0, wrd, sec, act};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sequencer_step(act, sec, wrd);
        if (mode != EXP_MODEL)
        begin
            step_out = {};
            if (mode == EXP_ONE)
            begin
                one = '{default: '0};
                one.done    = 1'b1;
                one.code    = code;
                one.found   = found;
                one.is_last = 1'b1;
                step_out.push_back(one);
            end
        end
        foreach (step_out[k])
            predicted_accesses.push_back(step_out[k]);
    endtask

    task automatic wait_results_out();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (predicted_accesses.size() != 0);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [28:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_IO_BASE)
            io_base_r = val[15:0];
        else
            sector_limit = val;
        @(posedge clk);
    endtask

    // feeds well-formed replies and write words, plus stray items when noisy, until the running request ends
    task automatic run_to_idle(input logic noisy);
        logic [15:0] w;
        logic [2:0]  act;
        while (seq_phase != PH_IDLE)
        begin
            w = 16'($urandom);
            if ($urandom_range(0, 63) == 0)
                wait_results_out();
            if (noisy && $urandom_range(0, 31) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: act = 3'($urandom_range(0, 2));
                    1: act = (seq_phase == PH_WR_DATA) ? ACT_REPLY : ACT_HOST_WR;
                    default: act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
                endcase
                offer(act, 28'($urandom), w, EXP_MODEL, RC_OK, 1'b0);
            end
            else
            begin
                case (seq_phase)
                    PH_PR_FIRST:
                        if (noisy && $urandom_range(0, 7) == 0)
                            w[7:0] = 8'h00;
                        else
                            w[ST_BSY] = 1'b1;
                    PH_PR_BUSY, PH_RD_BUSY, PH_WR_BUSY, PH_WR_FLUSH:
                        w[ST_BSY] = ($urandom_range(0, 2) == 0);
                    PH_PR_CHECK:
                    begin
                        w[ST_ERR] = noisy && ($urandom_range(0, 7) == 0);
                        w[ST_DRQ] = !noisy || ($urandom_range(0, 7) != 0);
                    end
                    PH_RD_DRQ, PH_WR_DRQ:
                    begin
                        w[ST_ERR] = noisy && ($urandom_range(0, 7) == 0);
                        w[ST_DRQ] = ($urandom_range(0, 2) != 0);
                    end
                    default:
                        ;
                endcase
                act = (seq_phase == PH_WR_DATA) ? ACT_HOST_WR : ACT_REPLY;
                offer(act, 28'($urandom), w, EXP_MODEL, RC_OK, 1'b0);
            end
        end
    endtask

    // result side: sample at the edge, compare once the edge has settled
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.op      = m_tdata[2:0];
            seen.addr    = m_tdata[18:3];
            seen.data    = m_tdata[34:19];
            seen.hword   = m_tdata[50:35];
            seen.done    = m_tdata[51];
            seen.code    = m_tdata[53:52];
            seen.found   = m_tdata[54];
            seen.hvalid  = m_tuser;
            seen.is_last = m_tlast;
            @(negedge clk);
            if (predicted_accesses.size() == 0)
                report({"unexpected item ", show(seen)});
            else if (seen.op !== predicted_accesses[0].op
                     || seen.addr !== predicted_accesses[0].addr
                     || seen.data !== predicted_accesses[0].data
                     || seen.hword !== predicted_accesses[0].hword
                     || seen.hvalid !== predicted_accesses[0].hvalid
                     || seen.done !== predicted_accesses[0].done
                     || seen.code !== predicted_accesses[0].code
                     || seen.found !== predicted_accesses[0].found
                     || seen.is_last !== predicted_accesses[0].is_last)
            begin
                report({"got ", show(seen), " want ", show(predicted_accesses[0])});
                void'(predicted_accesses.pop_front());
            end
            else
                void'(predicted_accesses.pop_front());
        end
    end

    // receiver: stretches of steady, random and sparse ready, plus one long hold
    initial
    begin
        int stretch;
        int pattern;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request != 0)
            begin
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stretch = $urandom_range(8, 64);
            pattern = $urandom_range(0, 2);
            repeat (stretch)
            begin
                case (pattern)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [2:0]  act;
        logic [27:0] sec;
        int          roll;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        mismatches    = 0;
        burst_left    = 0;
        hold_request  = 0;
        seq_phase     = PH_IDLE;
        words_done    = 0;
        model_present = 1'b0;
        io_base_r     = IO_BASE_RST;
        sector_limit  = MAX_SECTORS_RST;

        // directed rows, reset configuration
        plan.push_back('{ACT_READ, 28'h0000000, 16'h0000, EXP_ONE, RC_NO_DISK, 1'b0, 1'b0});
        plan.push_back('{ACT_WRITE, 28'hFFFFFFF, 16'hFFFF, EXP_ONE, RC_NO_DISK, 1'b0, 1'b0});
        plan.push_back('{ACT_REPLY, 28'hFFFFFFF, 16'hFFFF, EXP_NONE, RC_OK, 1'b0, 1'b0});
        plan.push_back('{ACT_HOST_WR, 28'hFFFFFFF, 16'hFFFF, EXP_NONE, RC_OK, 1'b0, 1'b0});
        plan.push_back('{ACT_SPARE_LO, 28'hFFFFFFF, 16'hFFFF, EXP_NONE, RC_OK, 1'b0, 1'b0});
        plan.push_back('{ACT_SPARE_MID, 28'h5555555, 16'hAAAA, EXP_NONE, RC_OK, 1'b0, 1'b0});
        plan.push_back('{ACT_SPARE_HI, 28'h0000000, 16'h0000, EXP_NONE, RC_OK, 1'b0, 1'b0});
        plan.push_back('{ACT_PROBE, 28'h0000000, 16'h0000, EXP_MODEL, RC_OK, 1'b0, 1'b0});
        plan.push_back('{ACT_READ, 28'h0000001, 16'h0000, EXP_ONE, RC_BUSY, 1'b0, 1'b0});
        // zero status byte on the first poll: nothing on the channel
        plan.push_back('{ACT_REPLY, 28'h0000000, 16'hFF00, EXP_ONE, RC_NO_DISK, 1'b0, 1'b0});
        plan.push_back('{ACT_PROBE, 28'hFFFFFFF, 16'hFFFF, EXP_MODEL, RC_OK, 1'b0, 1'b0});
        plan.push_back('{ACT_REPLY, 28'h0000000, 16'h0080, EXP_MODEL, RC_OK, 1'b0, 1'b0});
        plan.push_back('{ACT_REPLY, 28'h0000000, 16'h0080, EXP_MODEL, RC_OK, 1'b0, 1'b0});
        plan.push_back('{ACT_REPLY, 28'h0000000, 16'h007F, EXP_MODEL, RC_OK, 1'b0, 1'b0});
        // err after busy drops fails the identify
        plan.push_back('{ACT_REPLY, 28'h0000000, 16'h0009, EXP_ONE, RC_NO_DISK, 1'b0, 1'b0});
        plan.push_back('{ACT_PROBE, 28'h0000000, 16'h0000, EXP_MODEL, RC_OK, 1'b0, 1'b1});
        plan.push_back('{ACT_READ, 28'hFFFFFFF, 16'h0000, EXP_MODEL, RC_OK, 1'b0, 1'b1});
        plan.push_back('{ACT_WRITE, 28'h0000000, 16'h0000, EXP_MODEL, RC_OK, 1'b0, 1'b1});
        plan.push_back('{ACT_WRITE, 28'h5A5A5A5, 16'h0000, EXP_MODEL, RC_OK, 1'b0, 1'b0});
        plan.push_back('{ACT_PROBE, 28'h0000000, 16'h0000, EXP_ONE, RC_BUSY, 1'b1, 1'b0});
        plan.push_back('{ACT_HOST_WR, 28'h0000000, 16'h1234, EXP_NONE, RC_OK, 1'b1, 1'b0});
        plan.push_back('{ACT_REPLY, 28'h0000000, 16'h0000, EXP_MODEL, RC_OK, 1'b0, 1'b0});
        // err ends the drq wait of a write: data phase opens with no item out
        plan.push_back('{ACT_REPLY, 28'h0000000, 16'h0001, EXP_NONE, RC_OK, 1'b1, 1'b1});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            offer(plan[i].act, plan[i].sec, plan[i].wrd, plan[i].mode, plan[i].code,
                  plan[i].found);
            if (plan[i].complete)
                run_to_idle(1'b0);
        end

        for (int pass = 0; pass < 4; pass++)
        begin
            wait_results_out();
            repeat (SETTLE_CYCLES) @(posedge clk);
            case (pass)
                0:
                begin
                    set_register(CFG_IO_BASE, 29'h000FFFF);
                    set_register(CFG_MAX_SECTORS, 29'd0);
                end
                1:
                begin
                    set_register(CFG_IO_BASE, 29'd0);
                    set_register(CFG_MAX_SECTORS, MAX_SECTORS_RST);
                end
                2:
                begin
                    set_register(CFG_IO_BASE, 29'($urandom_range(0, 16'hFFFF)));
                    set_register(CFG_MAX_SECTORS, 29'($urandom_range(1, 32'h1000_0000)));
                    hold_request = 1;
                end
                default:
                begin
                    set_register(CFG_IO_BASE, {13'd0, IO_BASE_RST});
                    set_register(CFG_MAX_SECTORS, 29'd1);
                end
            endcase
            repeat (REQS_PER_PASS)
            begin
                // the occasional stray item while idle
                if ($urandom_range(0, 3) == 0)
                    offer(3'($urandom_range(ACT_REPLY, ACT_SPARE_HI)), 28'($urandom),
                          16'($urandom), EXP_MODEL, RC_OK, 1'b0);
                roll = $urandom_range(0, 7);
                if (!model_present)
                    act = (roll == 0) ? ACT_READ : (roll == 1) ? ACT_WRITE : ACT_PROBE;
                else
                    act = (roll == 0) ? ACT_PROBE : (roll < 5) ? ACT_READ : ACT_WRITE;
                case ($urandom_range(0, 3))
                    0: sec = 28'($urandom);
                    1: sec = 28'(sector_limit - 29'd1);
                    2: sec = 28'(sector_limit);
                    default:
                        sec = (sector_limit == 29'd0) ? 28'($urandom)
                            : 28'($urandom_range(0, 32'(sector_limit) - 1));
                endcase
                offer(act, sec, 16'($urandom), EXP_MODEL, RC_OK, 1'b0);
                run_to_idle(1'b1);
            end
        end

        wait_results_out();
        repeat (16) @(posedge clk);
        if (predicted_accesses.size() != 0)
            report($sformatf("%0d items never came out", predicted_accesses.size()));
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
rtl/apss_pkg.sv
rtl/ata_pio_sector_sequencer_unit.sv
bench/testbench.sv
